// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules of the temperature block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hw/rtl/tdwa_pkg.sv =====
// Package of the temperature display and window average block: widths, codes,
// the controller state type and the seven-segment table. No dependencies.
package tdwa_pkg;

   // Field and datapath widths.
   localparam int ADC_W   = 12;
   localparam int VAL_W   = 11;
   localparam int SPAN_W  = 13;
   localparam int NUMER_W = 21;
   localparam int FNUM_W  = 23;
   localparam int MAG_W   = 22;
   localparam int DEN_W   = 15;
   localparam int QUO_W   = 11;
   localparam int DSH_W   = DEN_W + QUO_W - 1;
   localparam int STEP_W  = 4;
   localparam int BIN_W   = 10;
   localparam int BCD_W   = 13;

   // Command codes of the request beat.
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_BYTE   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_CAL_LOW  = 2'd0;
   localparam logic [1:0] CSR_CAL_HIGH = 2'd1;
   localparam logic [1:0] CSR_UNIT     = 2'd2;

   // Result kinds, glyphs and the serial request byte.
   localparam logic       KIND_DISPLAY = 1'b0;
   localparam logic       KIND_AVERAGE = 1'b1;
   localparam logic [7:0] GLYPH_F      = 8'h8F;
   localparam logic [7:0] GLYPH_C      = 8'h9C;
   localparam logic [7:0] AVG_REQUEST  = 8'h30;

   // Clamp limits of a converted value.
   localparam logic signed [VAL_W-1:0] VAL_MIN     = -11'sd512;
   localparam logic signed [VAL_W-1:0] VAL_MAX     = 11'sd1023;
   localparam logic [QUO_W-1:0]        MAG_NEG_MAX = 11'd512;
   localparam logic [QUO_W-1:0]        MAG_POS_MAX = 11'd1023;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NUMER,
      ST_C_LOAD,
      ST_C_RUN,
      ST_C_SAVE,
      ST_F_LOAD,
      ST_F_RUN,
      ST_SHOW,
      ST_BCD,
      ST_DISP_OUT,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_AVG_LOAD,
      ST_AVG_RUN,
      ST_AVG_OUT
   } state_type;

   // Seven-segment code of one decimal digit.
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0: code = 8'hFC;
         4'd1: code = 8'h60;
         4'd2: code = 8'hDB;
         4'd3: code = 8'hF3;
         4'd4: code = 8'h67;
         4'd5: code = 8'hB7;
         4'd6: code = 8'hBF;
         4'd7: code = 8'hE4;
         4'd8: code = 8'hFF;
         4'd9: code = 8'hF7;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/temperature_display_and_window_average.sv =====
// Sample beat: the controller steps through NUMER, C_LOAD, C_RUN and C_SAVE, then F_LOAD and F_RUN
// when Fahrenheit is shown, then SHOW, BCD (for a value that is not negative) and DISP_OUT; a bad
// calibration span goes from NUMER straight to DISP_OUT. An average steps through AVG_LOAD, AVG_RUN
// and AVG_OUT, a tick through TICK_RD and TICK_WR. One beat at a time: a request is taken only in IDLE.
// A full result register stalls DISP_OUT and AVG_OUT. All three runs share one restoring divider (11 quotient bits).
// Reset (synchronous, active high) restores register defaults and empties the window by valid bits.
module temperature_display_and_window_average #(
   parameter int WINDOW_DEPTH = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [11:0] req_adc_value,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_unit_glyph,
   output logic [7:0]  rsp_lead_segments,
   output logic [7:0]  rsp_last_segments,
   output logic [7:0]  rsp_average_byte,
   output logic        rsp_range_error
);

   localparam int VAL_W  = tdwa_pkg::VAL_W;
   localparam int PTR_W  = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = VAL_W + $clog2(WINDOW_DEPTH);
   localparam int FNUM_W = tdwa_pkg::FNUM_W;
   localparam int MAG_W  = tdwa_pkg::MAG_W;
   localparam int DEN_W  = tdwa_pkg::DEN_W;
   localparam int QUO_W  = tdwa_pkg::QUO_W;
   localparam int DSH_W  = tdwa_pkg::DSH_W;

   // Configuration registers.
   logic [11:0] cal_low_ff;
   logic [11:0] cal_high_ff;
   logic        unit_ff;

   // Controller.
   tdwa_pkg::state_type state_ff, state_in;
   logic                        req_accept;
   logic                        slot_free;
   logic                        out_disp;
   logic                        out_avg;
   logic                        div_load;
   logic                        div_run;
   logic                        div_last;
   logic                        bcd_last;
   logic [tdwa_pkg::STEP_W-1:0] step_ff;

   // Conversion front end.
   logic [tdwa_pkg::ADC_W-1:0]           adc_ff;
   logic signed [tdwa_pkg::SPAN_W-1:0]   span;
   logic signed [tdwa_pkg::SPAN_W-1:0]   diff;
   logic signed [tdwa_pkg::NUMER_W-1:0]  diff_x;
   logic signed [tdwa_pkg::NUMER_W-1:0]  span_x;
   logic signed [tdwa_pkg::NUMER_W-1:0]  numer_calc;
   logic                                 span_ok;
   logic signed [tdwa_pkg::SPAN_W-1:0]   span_ff;
   logic signed [tdwa_pkg::NUMER_W-1:0]  numer_ff;
   logic signed [FNUM_W-1:0]             n_fx;
   logic signed [FNUM_W-1:0]             s_fx;
   logic signed [FNUM_W-1:0]             fnum_calc;
   logic signed [FNUM_W-1:0]             fnum_ff;
   logic [DEN_W-1:0]                     fden_ff;
   logic                                 err_ff;

   // Shared divider.
   logic signed [FNUM_W-1:0] load_num;
   logic [DEN_W-1:0]         load_den;
   logic [FNUM_W-1:0]        load_abs;
   logic [MAG_W-1:0]         load_mag;
   logic                     load_sat;
   logic [MAG_W-1:0]         div_rem_ff;
   logic [DSH_W-1:0]         div_den_ff;
   logic [QUO_W-1:0]         div_quo_ff;
   logic                     div_neg_ff;
   logic                     div_sat_ff;
   logic                     div_fit;
   logic signed [VAL_W-1:0]  div_val;
   logic signed [VAL_W-1:0]  last_cel_ff;

   // Serial BCD converter.
   logic [tdwa_pkg::BIN_W-1:0] bcd_bin_ff;
   logic [tdwa_pkg::BCD_W-1:0] bcd_ff;
   logic [tdwa_pkg::BCD_W-1:0] bcd_adj;
   logic [3:0]                 lead_digit;

   // Window ring.
   logic signed [VAL_W-1:0] win_mem_ff [WINDOW_DEPTH];
   logic signed [VAL_W-1:0] win_rd_ff;
   logic [WINDOW_DEPTH-1:0] win_valid_ff;
   logic [PTR_W-1:0]        ptr_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] old_x;
   logic signed [SUM_W-1:0] new_x;
   logic                    win_write;

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_kind_ff;
   logic [7:0] rsp_glyph_ff;
   logic [7:0] rsp_lead_ff;
   logic [7:0] rsp_last_ff;
   logic [7:0] rsp_avg_ff;
   logic       rsp_err_ff;

   assign req_ready  = (state_ff == tdwa_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign div_last   = (step_ff == tdwa_pkg::STEP_W'(QUO_W - 1));
   assign bcd_last   = (step_ff == tdwa_pkg::STEP_W'(tdwa_pkg::BIN_W - 1));

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff  <= '0;
         cal_high_ff <= '1;
         unit_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tdwa_pkg::CSR_CAL_LOW:  cal_low_ff  <= csr_write_data;
            tdwa_pkg::CSR_CAL_HIGH: cal_high_ff <= csr_write_data;
            tdwa_pkg::CSR_UNIT:     unit_ff     <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Next state and strobes.
   always_comb begin
      state_in  = state_ff;
      out_disp  = 1'b0;
      out_avg   = 1'b0;
      div_load  = 1'b0;
      div_run   = 1'b0;
      win_write = 1'b0;
      unique case (state_ff)
         tdwa_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  tdwa_pkg::CMD_SAMPLE: state_in = tdwa_pkg::ST_NUMER;
                  tdwa_pkg::CMD_TICK:   state_in = tdwa_pkg::ST_TICK_RD;
                  tdwa_pkg::CMD_BYTE: begin
                     if (req_rx_byte == tdwa_pkg::AVG_REQUEST) begin
                        state_in = tdwa_pkg::ST_AVG_LOAD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         tdwa_pkg::ST_NUMER: begin
            state_in = span_ok ? tdwa_pkg::ST_C_LOAD : tdwa_pkg::ST_DISP_OUT;
         end
         tdwa_pkg::ST_C_LOAD: begin
            div_load = 1'b1;
            state_in = tdwa_pkg::ST_C_RUN;
         end
         tdwa_pkg::ST_C_RUN: begin
            div_run = 1'b1;
            if (div_last) begin
               state_in = tdwa_pkg::ST_C_SAVE;
            end
         end
         tdwa_pkg::ST_C_SAVE: begin
            state_in = unit_ff ? tdwa_pkg::ST_SHOW : tdwa_pkg::ST_F_LOAD;
         end
         tdwa_pkg::ST_F_LOAD: begin
            div_load = 1'b1;
            state_in = tdwa_pkg::ST_F_RUN;
         end
         tdwa_pkg::ST_F_RUN: begin
            div_run = 1'b1;
            if (div_last) begin
               state_in = tdwa_pkg::ST_SHOW;
            end
         end
         tdwa_pkg::ST_SHOW: begin
            state_in = div_val[VAL_W-1] ? tdwa_pkg::ST_DISP_OUT : tdwa_pkg::ST_BCD;
         end
         tdwa_pkg::ST_BCD: begin
            if (bcd_last) begin
               state_in = tdwa_pkg::ST_DISP_OUT;
            end
         end
         tdwa_pkg::ST_DISP_OUT: begin
            if (slot_free) begin
               out_disp = 1'b1;
               state_in = tdwa_pkg::ST_IDLE;
            end
         end
         tdwa_pkg::ST_TICK_RD: begin
            state_in = tdwa_pkg::ST_TICK_WR;
         end
         tdwa_pkg::ST_TICK_WR: begin
            win_write = 1'b1;
            state_in  = tdwa_pkg::ST_IDLE;
         end
         tdwa_pkg::ST_AVG_LOAD: begin
            div_load = 1'b1;
            state_in = tdwa_pkg::ST_AVG_RUN;
         end
         tdwa_pkg::ST_AVG_RUN: begin
            div_run = 1'b1;
            if (div_last) begin
               state_in = tdwa_pkg::ST_AVG_OUT;
            end
         end
         tdwa_pkg::ST_AVG_OUT: begin
            if (slot_free) begin
               out_avg  = 1'b1;
               state_in = tdwa_pkg::ST_IDLE;
            end
         end
         default: state_in = tdwa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdwa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Calibration numerator N = (adc - low) * 55 + 30 * span, by shifts and adds.
   always_comb begin
      span       = $signed({1'b0, cal_high_ff}) - $signed({1'b0, cal_low_ff});
      diff       = $signed({1'b0, adc_ff}) - $signed({1'b0, cal_low_ff});
      span_ok    = !span[tdwa_pkg::SPAN_W-1] && (span != '0);
      diff_x     = {{(tdwa_pkg::NUMER_W - tdwa_pkg::SPAN_W){diff[tdwa_pkg::SPAN_W-1]}}, diff};
      span_x     = {{(tdwa_pkg::NUMER_W - tdwa_pkg::SPAN_W){span[tdwa_pkg::SPAN_W-1]}}, span};
      numer_calc = (diff_x <<< 6) - (diff_x <<< 3) - diff_x + (span_x <<< 5) - (span_x <<< 1);
   end

   // Fahrenheit numerator 9N + 160 * span over the divisor 5 * span.
   always_comb begin
      n_fx      = {{(FNUM_W - tdwa_pkg::NUMER_W){numer_ff[tdwa_pkg::NUMER_W-1]}}, numer_ff};
      s_fx      = {{(FNUM_W - tdwa_pkg::SPAN_W){span_ff[tdwa_pkg::SPAN_W-1]}}, span_ff};
      fnum_calc = (n_fx <<< 3) + n_fx + (s_fx <<< 7) + (s_fx <<< 5);
   end

   // Divider operand selection, magnitude and early overflow check.
   always_comb begin
      unique case (state_ff)
         tdwa_pkg::ST_F_LOAD: begin
            load_num = fnum_ff;
            load_den = fden_ff;
         end
         tdwa_pkg::ST_AVG_LOAD: begin
            load_num = {{(FNUM_W - SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
            load_den = DEN_W'(WINDOW_DEPTH);
         end
         default: begin
            load_num = n_fx;
            load_den = {3'b000, span_ff[11:0]};
         end
      endcase
      load_abs = load_num[FNUM_W-1] ? FNUM_W'(-load_num) : FNUM_W'(load_num);
      load_mag = load_abs[MAG_W-1:0];
      load_sat = {4'b0000, load_mag} >= {load_den, {QUO_W{1'b0}}};
      div_fit  = {3'b000, div_rem_ff} >= div_den_ff;
   end

   // Truncated quotient with its sign, clamped to the display range.
   always_comb begin
      if (div_sat_ff) begin
         div_val = div_neg_ff ? tdwa_pkg::VAL_MIN : tdwa_pkg::VAL_MAX;
      end else if (div_neg_ff) begin
         div_val = (div_quo_ff > tdwa_pkg::MAG_NEG_MAX) ? tdwa_pkg::VAL_MIN
                                                        : $signed(-div_quo_ff);
      end else begin
         div_val = (div_quo_ff > tdwa_pkg::MAG_POS_MAX) ? tdwa_pkg::VAL_MAX
                                                        : $signed(div_quo_ff);
      end
   end

   // Double-dabble adjust: every BCD digit of five or more gains three.
   always_comb begin
      bcd_adj = bcd_ff;
      if (bcd_ff[3:0] >= 4'd5) begin
         bcd_adj[3:0] = bcd_ff[3:0] + 4'd3;
      end
      if (bcd_ff[7:4] >= 4'd5) begin
         bcd_adj[7:4] = bcd_ff[7:4] + 4'd3;
      end
      if (bcd_ff[11:8] >= 4'd5) begin
         bcd_adj[11:8] = bcd_ff[11:8] + 4'd3;
      end
   end

   // Leading digit is the first nonzero BCD digit, or zero for a zero value.
   always_comb begin
      if (bcd_ff[12]) begin
         lead_digit = 4'd1;
      end else if (bcd_ff[11:8] != 4'd0) begin
         lead_digit = bcd_ff[11:8];
      end else if (bcd_ff[7:4] != 4'd0) begin
         lead_digit = bcd_ff[7:4];
      end else begin
         lead_digit = bcd_ff[3:0];
      end
   end

   // Datapath payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         adc_ff <= req_adc_value;
         err_ff <= 1'b0;
      end
      if (state_ff == tdwa_pkg::ST_NUMER) begin
         span_ff  <= span;
         numer_ff <= numer_calc;
         if (!span_ok) begin
            err_ff <= 1'b1;
         end
      end
      if (state_ff == tdwa_pkg::ST_C_LOAD) begin
         fnum_ff <= fnum_calc;
         fden_ff <= {1'b0, span_ff[11:0], 2'b00} + {3'b000, span_ff[11:0]};
      end
      if (state_ff == tdwa_pkg::ST_SHOW) begin
         bcd_bin_ff <= div_val[tdwa_pkg::BIN_W-1:0];
         bcd_ff     <= '0;
         if (div_val[VAL_W-1]) begin
            err_ff <= 1'b1;
         end
      end
      if (state_ff == tdwa_pkg::ST_BCD) begin
         bcd_ff     <= {bcd_adj[tdwa_pkg::BCD_W-2:0], bcd_bin_ff[tdwa_pkg::BIN_W-1]};
         bcd_bin_ff <= {bcd_bin_ff[tdwa_pkg::BIN_W-2:0], 1'b0};
      end
      // Divider: one quotient bit per cycle, divisor shifting right.
      if (div_load) begin
         div_rem_ff <= load_mag;
         div_den_ff <= {load_den, {(QUO_W - 1){1'b0}}};
         div_quo_ff <= '0;
         div_neg_ff <= load_num[FNUM_W-1];
         div_sat_ff <= load_sat;
      end else if (div_run) begin
         if (div_fit) begin
            div_rem_ff <= div_rem_ff - div_den_ff[MAG_W-1:0];
         end
         div_quo_ff <= {div_quo_ff[QUO_W-2:0], div_fit};
         div_den_ff <= {1'b0, div_den_ff[DSH_W-1:1]};
      end
   end

   // Step counter shared by the divider and the BCD converter.
   always_ff @(posedge clock) begin
      if (div_load || state_ff == tdwa_pkg::ST_SHOW) begin
         step_ff <= '0;
      end else if (div_run || state_ff == tdwa_pkg::ST_BCD) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   // Window storage with a registered read of the entry under the pointer.
   always_ff @(posedge clock) begin
      if (win_write) begin
         win_mem_ff[ptr_ff] <= last_cel_ff;
      end
      win_rd_ff <= win_mem_ff[ptr_ff];
   end

   assign old_x = win_valid_ff[ptr_ff]
                  ? {{(SUM_W - VAL_W){win_rd_ff[VAL_W-1]}}, win_rd_ff} : '0;
   assign new_x = {{(SUM_W - VAL_W){last_cel_ff[VAL_W-1]}}, last_cel_ff};

   // Ring control, running sum and the kept Celsius value.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         last_cel_ff  <= '0;
      end else begin
         if (state_ff == tdwa_pkg::ST_C_SAVE) begin
            last_cel_ff <= div_val;
         end
         if (win_write) begin
            win_valid_ff[ptr_ff] <= 1'b1;
            sum_ff               <= sum_ff - old_x + new_x;
            ptr_ff <= (ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         end
      end
   end

   // Result register: a finished beat waits here while the next request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_disp || out_avg) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_disp) begin
         rsp_kind_ff  <= tdwa_pkg::KIND_DISPLAY;
         rsp_glyph_ff <= unit_ff ? tdwa_pkg::GLYPH_C : tdwa_pkg::GLYPH_F;
         rsp_lead_ff  <= err_ff ? 8'h00 : tdwa_pkg::seg_code(lead_digit);
         rsp_last_ff  <= err_ff ? 8'h00 : tdwa_pkg::seg_code(bcd_ff[3:0]);
         rsp_avg_ff   <= 8'h00;
         rsp_err_ff   <= err_ff;
      end else if (out_avg) begin
         rsp_kind_ff  <= tdwa_pkg::KIND_AVERAGE;
         rsp_glyph_ff <= 8'h00;
         rsp_lead_ff  <= 8'h00;
         rsp_last_ff  <= 8'h00;
         rsp_avg_ff   <= div_val[7:0];
         rsp_err_ff   <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_unit_glyph    = rsp_glyph_ff;
   assign rsp_lead_segments = rsp_lead_ff;
   assign rsp_last_segments = rsp_last_ff;
   assign rsp_average_byte  = rsp_avg_ff;
   assign rsp_range_error   = rsp_err_ff;

endmodule

// ===== hw/rtl/tdwa_checker.sv =====
// Port-level checker of the temperature display and window average block.
// Depends on tdwa_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module tdwa_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_write_enable,
   input logic [1:0]  csr_index,
   input logic [11:0] csr_write_data,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_cmd,
   input logic [11:0] req_adc_value,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_unit_glyph,
   input logic [7:0]  rsp_lead_segments,
   input logic [7:0]  rsp_last_segments,
   input logic [7:0]  rsp_average_byte,
   input logic        rsp_range_error
);

   // A stalled result beat stays put.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_average_byte) && $stable(rsp_lead_segments), "result beat changed while stalled")

   // A display update carries a unit glyph and no average.
   `ASSERT_IMPLY(a_disp_fields, clock, reset, rsp_valid && rsp_kind == tdwa_pkg::KIND_DISPLAY, (rsp_unit_glyph == tdwa_pkg::GLYPH_F || rsp_unit_glyph == tdwa_pkg::GLYPH_C) && rsp_average_byte == 8'h00, "bad display update fields")

   // An average reply leaves the display fields clear.
   `ASSERT_IMPLY(a_avg_fields, clock, reset, rsp_valid && rsp_kind == tdwa_pkg::KIND_AVERAGE, rsp_unit_glyph == 8'h00 && rsp_lead_segments == 8'h00 && rsp_last_segments == 8'h00 && !rsp_range_error, "bad average reply fields")

   // A range error blanks both digits.
   `ASSERT_IMPLY(a_err_blank, clock, reset, rsp_valid && rsp_range_error, rsp_lead_segments == 8'h00 && rsp_last_segments == 8'h00, "range error with digits shown")

   // A sample keeps the block busy on the following cycle.
   `ASSERT_NEXT(a_sample_busy, clock, reset, req_valid && req_ready && req_cmd == tdwa_pkg::CMD_SAMPLE, !req_ready, "ready right after a sample beat")

endmodule

bind temperature_display_and_window_average tdwa_checker u_tdwa_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the temperature display and window average block.
// Depends on tdwa_pkg (codes, glyphs, register indexes) and the block's top module.
module testbench;

   localparam int WINDOW_SLOTS   = 10;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int BEATS_PER_PHASE = 88;

   // Command code the block leaves unused.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] adc;
      logic [7:0]  rx;
   } temp_request_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] glyph;
      logic [7:0] lead_seg;
      logic [7:0] last_seg;
      logic [7:0] average;
      logic       range_err;
   } temp_reply_type;

   // Block ports; the inputs are all known from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = tdwa_pkg::CSR_CAL_LOW;
   logic [11:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = tdwa_pkg::CMD_SAMPLE;
   logic [11:0] req_adc_value = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_unit_glyph;
   logic [7:0]  rsp_lead_segments;
   logic [7:0]  rsp_last_segments;
   logic [7:0]  rsp_average_byte;
   logic        rsp_range_error;

   // Stimulus and expectation stores.
   temp_request_type requests_pending[$];
   temp_reply_type   replies_due[$];
   temp_request_type next_request;
   bit            beat_taken = 1'b0;
   int            sender_idle_pct = 0;
   int            receiver_stall_pct = 0;

   // Shadow of the block's registers and window state.
   int  cal_low_m = 0;
   int  cal_high_m = 4095;
   bit  show_celsius_m = 1'b0;
   int  last_celsius_m = 0;
   int  window_m [WINDOW_SLOTS];
   int  write_slot_m = 0;
   int  window_sum_m = 0;
   logic [7:0] digit_segments [10] = '{8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67,
                                       8'hB7, 8'hBF, 8'hE4, 8'hFF, 8'hF7};

   // Run statistics.
   int error_count = 0;
   int beats_accepted = 0;
   int replies_checked = 0;
   int average_replies = 0;
   int range_errors_seen = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   temperature_display_and_window_average #(
      .WINDOW_DEPTH(WINDOW_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_adc_value(req_adc_value),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_unit_glyph(rsp_unit_glyph),
      .rsp_lead_segments(rsp_lead_segments),
      .rsp_last_segments(rsp_last_segments),
      .rsp_average_byte(rsp_average_byte),
      .rsp_range_error(rsp_range_error)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Clamp a converted reading to the displayable range.
   function automatic longint clamp_reading(input longint v);
      if (v < -512) return -512;
      if (v > 1023) return 1023;
      return v;
   endfunction

   // Update the shadow state for one accepted request and queue any reply it causes.
   task automatic predict_reply(input temp_request_type beat);
      temp_reply_type reply;
      longint span, numer, cval, fval, shown, lead_val;
      int avg;
      reply = '0;
      if (beat.cmd == tdwa_pkg::CMD_SAMPLE) begin
         reply.kind = tdwa_pkg::KIND_DISPLAY;
         reply.glyph = show_celsius_m ? tdwa_pkg::GLYPH_C : tdwa_pkg::GLYPH_F;
         reply.range_err = 1'b1;
         span = longint'(cal_high_m) - longint'(cal_low_m);
         if (span > 0) begin
            numer = (longint'(beat.adc) - longint'(cal_low_m)) * 55 + 30 * span;
            cval = clamp_reading(numer / span);
            fval = clamp_reading((9 * numer + 160 * span) / (5 * span));
            shown = show_celsius_m ? cval : fval;
            last_celsius_m = int'(cval);
            if (shown >= 0) begin
               lead_val = shown;
               while (lead_val >= 10) lead_val = lead_val / 10;
               reply.range_err = 1'b0;
               reply.lead_seg = digit_segments[int'(lead_val)];
               reply.last_seg = digit_segments[int'(shown % 10)];
            end
         end
         replies_due.push_back(reply);
      end else if (beat.cmd == tdwa_pkg::CMD_TICK) begin
         // The tick overwrites the oldest window entry with the kept Celsius value.
         window_sum_m = window_sum_m - window_m[write_slot_m] + last_celsius_m;
         window_m[write_slot_m] = last_celsius_m;
         write_slot_m = (write_slot_m + 1) % WINDOW_SLOTS;
      end else if (beat.cmd == tdwa_pkg::CMD_BYTE && beat.rx == tdwa_pkg::AVG_REQUEST) begin
         avg = window_sum_m / WINDOW_SLOTS;
         reply.kind = tdwa_pkg::KIND_AVERAGE;
         reply.average = avg[7:0];
         replies_due.push_back(reply);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Request driver: new beats appear at the falling edge and hold until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (requests_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_request = requests_pending.pop_front();
            req_cmd <= next_request.cmd;
            req_adc_value <= next_request.adc;
            req_rx_byte <= next_request.rx;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Reply back-pressure.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Monitor: predicts on each request beat, checks each reply beat, guards against hangs.
   always @(posedge clock) begin
      beat_taken = !reset && req_valid && req_ready;
      if (!reset) begin
         if (beat_taken) begin
            predict_reply('{cmd: req_cmd, adc: req_adc_value, rx: req_rx_byte});
            beats_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected reply, expected none, actual kind %0b glyph %0h",
                        $time, rsp_kind, rsp_unit_glyph);
               error_count++;
            end else begin
               temp_reply_type want;
               want = replies_due.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("unit_glyph", want.glyph, rsp_unit_glyph);
               check_field("lead_segments", want.lead_seg, rsp_lead_segments);
               check_field("last_segments", want.last_seg, rsp_last_segments);
               check_field("average_byte", want.average, rsp_average_byte);
               check_field("range_error", want.range_err, rsp_range_error);
            end
            replies_checked++;
            if (rsp_kind == tdwa_pkg::KIND_AVERAGE) average_replies++;
            if (rsp_range_error) range_errors_seen++;
         end
         if (beat_taken || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Hold off until every queued request is taken and every reply is back,
   // then give a tick beat time to finish inside the block. The check runs at
   // the rising edge, where the driver's outputs and queue are settled.
   task automatic wait_until_quiet();
      while (requests_pending.size() != 0 || req_valid || replies_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write all three registers on consecutive cycles while the block is idle.
   task automatic load_calibration(input int low, input int high, input bit celsius);
      wait_until_quiet();
      csr_write_enable <= 1'b1;
      csr_index <= tdwa_pkg::CSR_CAL_LOW;
      csr_write_data <= 12'(low);
      @(negedge clock);
      csr_index <= tdwa_pkg::CSR_CAL_HIGH;
      csr_write_data <= 12'(high);
      @(negedge clock);
      csr_index <= tdwa_pkg::CSR_UNIT;
      csr_write_data <= 12'(celsius);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cal_low_m = low;
      cal_high_m = high;
      show_celsius_m = celsius;
      settings_used++;
   endtask

   task automatic add_request(input logic [1:0] cmd, input int adc, input int rx);
      requests_pending.push_back('{cmd: cmd, adc: 12'(adc), rx: 8'(rx)});
   endtask

   // Random traffic, mostly samples feeding ticks and average requests, with
   // ignored bytes and the unused command mixed in.
   task automatic queue_random_requests(input int count);
      int made, pick, span, adc;
      made = 0;
      span = cal_high_m - cal_low_m;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            if (span > 0 && $urandom_range(0, 1) == 1) begin
               adc = cal_low_m - span / 2 + int'($urandom_range(0, 2 * span));
               if (adc < 0) adc = 0;
               if (adc > 4095) adc = 4095;
            end else begin
               adc = $urandom_range(0, 4095);
            end
            add_request(tdwa_pkg::CMD_SAMPLE, adc, $urandom_range(0, 255));
         end else if (pick < 70) begin
            add_request(tdwa_pkg::CMD_TICK, $urandom_range(0, 4095), $urandom_range(0, 255));
         end else if (pick < 94) begin
            if ($urandom_range(0, 9) < 7) begin
               add_request(tdwa_pkg::CMD_BYTE, $urandom_range(0, 4095), tdwa_pkg::AVG_REQUEST);
            end else begin
               add_request(tdwa_pkg::CMD_BYTE, $urandom_range(0, 4095), $urandom_range(0, 255));
            end
         end else begin
            add_request(CMD_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 255));
         end
         made++;
      end
   endtask

   // Sequencer: directed checks first, then random phases over several settings.
   initial begin
      int low, high;
      bit celsius;
      foreach (window_m[k]) window_m[k] = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: extreme samples, empty-window average, ignored items.
      add_request(tdwa_pkg::CMD_SAMPLE, 0, 8'h00);
      add_request(tdwa_pkg::CMD_SAMPLE, 4095, 8'hFF);
      add_request(tdwa_pkg::CMD_SAMPLE, 12'hAAA, 8'h55);
      add_request(tdwa_pkg::CMD_BYTE, 0, tdwa_pkg::AVG_REQUEST);
      add_request(tdwa_pkg::CMD_TICK, 0, 0);
      add_request(tdwa_pkg::CMD_BYTE, 12'h555, tdwa_pkg::AVG_REQUEST);
      add_request(CMD_UNUSED, 4095, 8'hFF);
      add_request(tdwa_pkg::CMD_BYTE, 0, 8'h31);
      add_request(tdwa_pkg::CMD_BYTE, 4095, 8'hCF);

      // Celsius with a narrow span: zero reading, negative reading kept in the window.
      load_calibration(2000, 2500, 1'b1);
      add_request(tdwa_pkg::CMD_SAMPLE, 1727, 0);
      add_request(tdwa_pkg::CMD_TICK, 0, 0);
      add_request(tdwa_pkg::CMD_SAMPLE, 0, 0);
      add_request(tdwa_pkg::CMD_TICK, 0, 0);
      add_request(tdwa_pkg::CMD_TICK, 0, 0);
      add_request(tdwa_pkg::CMD_BYTE, 0, tdwa_pkg::AVG_REQUEST);
      add_request(tdwa_pkg::CMD_SAMPLE, 4095, 0);
      add_request(tdwa_pkg::CMD_BYTE, 0, tdwa_pkg::AVG_REQUEST);

      // Zero span and negative span both blank the display.
      load_calibration(2048, 2048, 1'b0);
      add_request(tdwa_pkg::CMD_SAMPLE, 100, 0);
      add_request(tdwa_pkg::CMD_BYTE, 0, tdwa_pkg::AVG_REQUEST);
      load_calibration(4095, 0, 1'b1);
      add_request(tdwa_pkg::CMD_SAMPLE, 4095, 0);

      // Span of one count drives both units into the upper clamp.
      load_calibration(0, 1, 1'b0);
      add_request(tdwa_pkg::CMD_SAMPLE, 4095, 0);
      add_request(tdwa_pkg::CMD_TICK, 0, 0);
      add_request(tdwa_pkg::CMD_BYTE, 0, tdwa_pkg::AVG_REQUEST);

      // Random phases, each with its own calibration and one of four idling patterns.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin low = 1000; high = 1500; celsius = 1'b1; end
            1: begin low = 0;    high = 4095; celsius = 1'b0; end
            2: begin low = 4094; high = 4095; celsius = 1'b1; end
            3: begin low = 0;    high = 1;    celsius = 1'b0; end
            4: begin low = 3000; high = 3000; celsius = 1'b1; end
            5: begin low = 4095; high = 0;    celsius = 1'b0; end
            default: begin
               low = $urandom_range(0, 3000);
               high = low + int'($urandom_range(1, 1095));
               celsius = $urandom_range(0, 1);
            end
         endcase
         load_calibration(low, high, celsius);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         queue_random_requests(BEATS_PER_PHASE);
      end

      wait_until_quiet();
      $display("Run covered %0d request beats over %0d register settings.",
               beats_accepted, settings_used);
      $display("Checked %0d replies: %0d averages, %0d with range error; %0d errors.",
               replies_checked, average_replies, range_errors_seen, error_count);
      if (error_count == 0 && replies_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tdwa_pkg.sv
hw/rtl/temperature_display_and_window_average.sv
hw/rtl/tdwa_checker.sv
bench/testbench.sv
